### design/asma_pkg.sv
package asma_pkg;

    // scan and averaging geometry
    localparam int MAX_SLOTS      = 8;
    localparam int SLOT_BITS      = 3;
    localparam int IDX_BITS       = 4;
    localparam int AVG_SAMPLES    = 1 << IDX_BITS;
    localparam int SAMPLE_BITS    = 10;
    localparam int SUM_BITS       = SAMPLE_BITS + IDX_BITS;
    localparam int CHAN_BITS      = 4;
    localparam int MAP_BITS       = 64;
    localparam int COUNT_BITS     = 4;
    localparam int CFG_IDX_BITS   = 2;
    localparam int RING_ADDR_BITS = SLOT_BITS + IDX_BITS;
    localparam int RING_DEPTH     = MAX_SLOTS * AVG_SAMPLES;

    typedef logic [SLOT_BITS-1:0]      slot_t;
    typedef logic [IDX_BITS-1:0]       idx_t;
    typedef logic [SAMPLE_BITS-1:0]    sample_t;
    typedef logic [SUM_BITS-1:0]       sum_t;
    typedef logic [CHAN_BITS-1:0]      chan_t;
    typedef logic [MAP_BITS-1:0]       map_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [CFG_IDX_BITS-1:0]   cfg_idx_t;
    typedef logic [RING_ADDR_BITS-1:0] ring_addr_t;

    // register indexes of the configuration port
    localparam cfg_idx_t REG_ACTIVE_SLOTS = cfg_idx_t'(0);
    localparam cfg_idx_t REG_CHANNEL_MAP  = cfg_idx_t'(1);

    // reset values of the configuration registers
    localparam count_t ACTIVE_SLOTS_RESET = count_t'(MAX_SLOTS);
    localparam map_t   CHANNEL_MAP_RESET  = map_t'(64'h0000_0000_7654_3210);

    // sample ring read request
    typedef struct packed {
        logic       en;
        ring_addr_t addr;
    } ring_rd_t;

    // sample ring write request
    typedef struct packed {
        logic       en;
        ring_addr_t addr;
        sample_t    data;
    } ring_wr_t;

    // physical channel of a slot
    function automatic chan_t slot_channel(map_t map, slot_t slot);
        return map[slot * CHAN_BITS +: CHAN_BITS];
    endfunction

    // number of scanned slots, zero taken as one, saturated at the maximum
    function automatic logic [SLOT_BITS:0] slot_count(count_t active);
        logic [SLOT_BITS:0] n;
        if (active == '0)
            n = (SLOT_BITS+1)'(1);
        else if (active > count_t'(MAX_SLOTS))
            n = (SLOT_BITS+1)'(MAX_SLOTS);
        else
            n = (SLOT_BITS+1)'(active);
        return n;
    endfunction

endpackage

### design/asma_if.sv
interface asma_sample_if;
    import asma_pkg::*;
    logic    valid;
    logic    ready;
    sample_t adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface asma_avg_if;
    import asma_pkg::*;
    logic    valid;
    logic    ready;
    logic    avg_valid;
    chan_t   avg_channel;
    sample_t avg_value;
    chan_t   next_channel;

    modport source (output valid, output avg_valid, output avg_channel,
                    output avg_value, output next_channel, input ready);
    modport sink   (input valid, input avg_valid, input avg_channel,
                    input avg_value, input next_channel, output ready);
endinterface

interface asma_cfg_if;
    import asma_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    map_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/asma_ring.sv
module asma_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  asma_pkg::ring_rd_t rd,
    input  asma_pkg::ring_wr_t wr,
    output asma_pkg::sample_t  rd_data
);
    import asma_pkg::*;

    sample_t                 mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]   written_reg;
    sample_t                 rd_data_reg;
    logic                    rd_hit_reg;
    logic                    fwd;

    // a write to the address being read wins over the stored word
    assign fwd = wr.en && (wr.addr == rd.addr);

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    // registered read data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            if (fwd)
                rd_data_reg <= wr.data;
            else
                rd_data_reg <= mem[rd.addr];
        end
    end

    // per-entry written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
                written_reg[wr.addr] <= 1'b1;
            if (rd.en)
                rd_hit_reg <= fwd || written_reg[rd.addr];
        end
    end

    // never written entries read as zero
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

### design/adc_scan_moving_average.sv
// channel      | dir | payload                                           | handshake
// sample_ch    | in  | adc_sample                                        | valid/ready
// avg_ch       | out | avg_valid, avg_channel, avg_value, next_channel   | valid/ready
// cfg_ch       | in  | index, data                                       | valid/ready (always ready)
//
// One sample per cycle sustained while the output is taken; the ring read is issued
// with the accepting edge, the sum update runs from the ring read stage, and the
// result is registered in the output register, from which the consumer takes it.
// The ring memory holds 128 entries, each flagged unwritten after reset and read as zero.
// Reset clears the scan position, ring indexes, running sums and ring flags.
// A stalled result holds in the output register while one more sample waits in
// the ring read stage; input ready drops only when both are full.
module adc_scan_moving_average (
    input logic          clk,
    input logic          rst_n,
    asma_sample_if.sink  sample_ch,
    asma_avg_if.source   avg_ch,
    asma_cfg_if.sink     cfg_ch
);
    import asma_pkg::*;

    // configuration
    count_t active_slots_reg;
    map_t   channel_map_reg;

    // scan state
    slot_t  current_slot_reg;
    slot_t  current_slot_next;
    idx_t   ring_index_reg [MAX_SLOTS];
    sum_t   running_sum_reg [MAX_SLOTS];

    // ring read stage
    logic       s1_valid_reg;
    slot_t      s1_slot_reg;
    ring_addr_t s1_addr_reg;
    sample_t    s1_sample_reg;
    logic       s1_wrap_reg;
    chan_t      s1_chan_reg;
    chan_t      s1_next_chan_reg;

    // output register
    logic    out_valid_reg;
    logic    out_avg_valid_reg;
    chan_t   out_avg_channel_reg;
    sample_t out_avg_value_reg;
    chan_t   out_next_channel_reg;

    logic       accept;
    logic       out_free;
    logic       s1_advance;
    idx_t       cur_idx;
    logic       cur_wrap;
    idx_t       ring_index_next;
    ring_rd_t   ring_rd;
    ring_wr_t   ring_wr;
    sample_t    old_sample;
    sum_t       sum_next;
    sample_t    avg_next;

    // configuration writes
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg <= ACTIVE_SLOTS_RESET;
            channel_map_reg  <= CHANNEL_MAP_RESET;
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == REG_ACTIVE_SLOTS)
                active_slots_reg <= cfg_ch.data[COUNT_BITS-1:0];
            else if (cfg_ch.index == REG_CHANNEL_MAP)
                channel_map_reg <= cfg_ch.data;
        end
    end

    // pipeline flow control
    assign out_free        = !out_valid_reg || avg_ch.ready;
    assign s1_advance      = s1_valid_reg && out_free;
    assign sample_ch.ready = !s1_valid_reg || out_free;
    assign accept          = sample_ch.valid && sample_ch.ready;

    // slot and ring position of the incoming sample
    assign cur_idx         = ring_index_reg[current_slot_reg];
    assign cur_wrap        = (cur_idx == idx_t'(AVG_SAMPLES - 1));
    assign ring_index_next = cur_wrap ? '0 : cur_idx + idx_t'(1);

    always_comb
    begin
        if (({1'b0, current_slot_reg} + (SLOT_BITS+1)'(1)) >= slot_count(active_slots_reg))
            current_slot_next = '0;
        else
            current_slot_next = current_slot_reg + slot_t'(1);
    end

    // ring memory requests
    always_comb
    begin
        ring_rd.en   = accept;
        ring_rd.addr = {current_slot_reg, cur_idx};
        ring_wr.en   = s1_advance;
        ring_wr.addr = s1_addr_reg;
        ring_wr.data = s1_sample_reg;
    end

    asma_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (ring_rd),
        .wr      (ring_wr),
        .rd_data (old_sample)
    );

    // scan position and ring indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_slot_reg <= '0;
            for (int i = 0; i < MAX_SLOTS; i++)
                ring_index_reg[i] <= '0;
        end
        else if (accept)
        begin
            current_slot_reg                 <= current_slot_next;
            ring_index_reg[current_slot_reg] <= ring_index_next;
        end
    end

    // ring read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    // ring read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg      <= current_slot_reg;
            s1_addr_reg      <= {current_slot_reg, cur_idx};
            s1_sample_reg    <= sample_ch.adc_sample;
            s1_wrap_reg      <= cur_wrap;
            s1_chan_reg      <= slot_channel(channel_map_reg, current_slot_reg);
            s1_next_chan_reg <= slot_channel(channel_map_reg, current_slot_next);
        end
    end

    // running sum update and average
    assign sum_next = running_sum_reg[s1_slot_reg] + sum_t'(s1_sample_reg) - sum_t'(old_sample);
    assign avg_next = s1_wrap_reg ? sum_next[SUM_BITS-1:IDX_BITS] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
                running_sum_reg[i] <= '0;
        end
        else if (s1_advance)
            running_sum_reg[s1_slot_reg] <= sum_next;
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (avg_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_avg_valid_reg    <= s1_wrap_reg;
            out_avg_channel_reg  <= s1_chan_reg;
            out_avg_value_reg    <= avg_next;
            out_next_channel_reg <= s1_next_chan_reg;
        end
    end

    assign avg_ch.valid        = out_valid_reg;
    assign avg_ch.avg_valid    = out_avg_valid_reg;
    assign avg_ch.avg_channel  = out_avg_channel_reg;
    assign avg_ch.avg_value    = out_avg_value_reg;
    assign avg_ch.next_channel = out_next_channel_reg;

endmodule
